/* hdl/tgl_pkg.sv */
package tgl_pkg;

	typedef enum logic [1:0] {
		CMD_TEXT  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_PEN   = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_BOX_LEFT   = 3'd0,
		REG_BOX_TOP    = 3'd1,
		REG_BOX_WIDTH  = 3'd2,
		REG_CHAR_SIZE  = 3'd3,
		REG_CHAR_GAP   = 3'd4,
		REG_LINE_LEAD  = 3'd5,
		REG_KINSOKU    = 3'd6,
		REG_TYPE_SPEED = 3'd7
	} reg_idx_t;

	typedef enum logic [6:0] {
		M_IDLE      = 7'b0000001,
		M_ESC       = 7'b0000010,
		M_ESC_SKIP  = 7'b0000100,
		M_LEAD      = 7'b0001000,
		M_RUBY_BASE = 7'b0010000,
		M_RUBY_LEAD = 7'b0100000,
		M_RUBY_READ = 7'b1000000
	} mode_t;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_BRACE_OPEN = 8'h7B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;
	localparam logic [7:0] CH_ESC_CLEAR = 8'h63;
	localparam logic [7:0] CH_ESC_NEWLINE = 8'h6E;
	localparam logic [7:0] CH_ESC_WAIT = 8'h77;

	localparam logic [15:0] HANG_COMMA = 16'h8141;
	localparam logic [15:0] HANG_PERIOD = 16'h8142;
	localparam logic [15:0] HANG_QUOTE_A = 16'h8176;
	localparam logic [15:0] HANG_QUOTE_B = 16'h8178;

	localparam logic [7:0] LEAD_LO_MIN = 8'h81;
	localparam logic [7:0] LEAD_LO_MAX = 8'h9F;
	localparam logic [7:0] LEAD_HI_MIN = 8'hE0;
	localparam logic [7:0] LEAD_HI_MAX = 8'hFC;

	// ceil(2^18 / 5): floor(s * RECIP5 >> 18) == floor(s / 5) for any 16-bit s
	localparam logic [15:0] RECIP5 = 16'd52429;
	localparam int STEP_W = 14;

	typedef struct packed {
		logic [15:0]        box_left;
		logic [15:0]        box_top;
		logic [17:0]        limit;      // signed, box_left + box_width - size - gap
		logic [8:0]         adv_full;
		logic [8:0]         adv_half;
		logic [8:0]         line_step;
		logic               kinsoku;
		logic [STEP_W-1:0]  step;
	} cfg_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  text_byte;
		logic        end_of_string;
		logic [15:0] new_pen_x;
		logic [15:0] new_pen_y;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] glyph_code;
		logic [15:0] glyph_x;
		logic [15:0] glyph_y;
		logic [31:0] start_ms;
	} result_t;

	function automatic logic is_lead(input logic [7:0] c);
		return (c >= LEAD_LO_MIN && c <= LEAD_LO_MAX) ||
			(c >= LEAD_HI_MIN && c <= LEAD_HI_MAX);
	endfunction

	function automatic logic is_hanging(input logic [15:0] code);
		return code == HANG_COMMA || code == HANG_PERIOD ||
			code == HANG_QUOTE_A || code == HANG_QUOTE_B;
	endfunction

endpackage

/* hdl/tgl_in_if.sv */
interface tgl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  text_byte;
	logic        end_of_string;
	logic [15:0] new_pen_x;
	logic [15:0] new_pen_y;

	modport source (output valid, cmd, text_byte, end_of_string, new_pen_x, new_pen_y,
		input ready);
	modport sink (input valid, cmd, text_byte, end_of_string, new_pen_x, new_pen_y,
		output ready);
endinterface

/* hdl/tgl_out_if.sv */
interface tgl_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] glyph_code;
	logic [15:0] glyph_x;
	logic [15:0] glyph_y;
	logic [31:0] start_ms;

	modport source (output valid, kind, glyph_code, glyph_x, glyph_y, start_ms,
		input ready);
	modport sink (input valid, kind, glyph_code, glyph_x, glyph_y, start_ms,
		output ready);
endinterface

/* hdl/tgl_cfg.sv */
module tgl_cfg
	import tgl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	logic [15:0] box_left_q, box_top_q, type_speed_q;
	logic [14:0] box_width_q;
	logic [7:0]  char_size_q, char_gap_q, line_lead_q;
	logic        kinsoku_q;

	logic [17:0]        limit_q;
	logic [8:0]         adv_full_q, adv_half_q, line_step_q;
	logic [STEP_W-1:0]  step_q;
	logic [31:0]        speed_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_width_q  <= '0;
			char_size_q  <= 8'd27;
			char_gap_q   <= '0;
			line_lead_q  <= '0;
			kinsoku_q    <= 1'b1;
			type_speed_q <= 16'd100;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BOX_LEFT:   box_left_q   <= cfg_data;
				REG_BOX_TOP:    box_top_q    <= cfg_data;
				REG_BOX_WIDTH:  box_width_q  <= cfg_data[14:0];
				REG_CHAR_SIZE:  char_size_q  <= cfg_data[7:0];
				REG_CHAR_GAP:   char_gap_q   <= cfg_data[7:0];
				REG_LINE_LEAD:  line_lead_q  <= cfg_data[7:0];
				REG_KINSOKU:    kinsoku_q    <= cfg_data[0];
				REG_TYPE_SPEED: type_speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign speed_prod = type_speed_q * RECIP5;

	// derived values are registered again after the configuration registers; the input stage covers that delay
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= -18'sd27;
			adv_full_q  <= 9'd27;
			adv_half_q  <= 9'd13;
			line_step_q <= 9'd27;
			step_q      <= STEP_W'(20);
		end else begin
			limit_q     <= {{2{box_left_q[15]}}, box_left_q} + {3'b0, box_width_q}
				- {10'b0, char_size_q} - {10'b0, char_gap_q};
			adv_full_q  <= {1'b0, char_size_q} + {1'b0, char_gap_q};
			adv_half_q  <= {2'b0, char_size_q[7:1]} + {1'b0, char_gap_q};
			line_step_q <= {1'b0, char_size_q} + {1'b0, line_lead_q};
			step_q      <= speed_prod[18 +: STEP_W];
		end
	end

	always_comb begin
		cfg.box_left  = box_left_q;
		cfg.box_top   = box_top_q;
		cfg.limit     = limit_q;
		cfg.adv_full  = adv_full_q;
		cfg.adv_half  = adv_half_q;
		cfg.line_step = line_step_q;
		cfg.kinsoku   = kinsoku_q;
		cfg.step      = step_q;
	end

endmodule

/* hdl/tgl_layout.sv */
module tgl_layout
	import tgl_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output logic    res_valid,
	output result_t res
);

	mode_t       mode_q, mode_d;
	logic [7:0]  lead_q, lead_d;
	logic [15:0] col_q, col_d, row_q, row_d;
	logic [31:0] time_q, time_d;

	logic        do_place, do_break, do_clear, full, may_hang, brk;
	logic [15:0] code, pcol, prow;
	logic [7:0]  c;
	logic [32:0] tsum;

	assign c = item.text_byte;

	always_comb begin
		mode_d   = mode_q;
		lead_d   = lead_q;
		do_place = 1'b0;
		do_break = 1'b0;
		do_clear = 1'b0;
		full     = 1'b0;
		may_hang = 1'b0;
		code     = {8'h00, c};

		case (item.cmd)
			CMD_CLEAR: do_clear = 1'b1;
			CMD_TEXT: begin
				unique case (mode_q)
					M_ESC: begin
						mode_d = M_IDLE;
						if (c == CH_ESC_CLEAR) do_clear = 1'b1;
						else if (c == CH_ESC_NEWLINE) do_break = 1'b1;
						else if (c == CH_ESC_WAIT) mode_d = M_ESC_SKIP;
					end
					M_ESC_SKIP: mode_d = M_IDLE;
					M_LEAD: begin
						mode_d   = M_IDLE;
						code     = {lead_q, c};
						do_place = 1'b1;
						full     = 1'b1;
						may_hang = 1'b1;
					end
					M_RUBY_BASE: begin
						if (c == CH_SLASH) mode_d = M_RUBY_READ;
						else if (c == CH_BRACE_CLOSE) mode_d = M_IDLE;
						else if (is_lead(c)) begin
							lead_d = c;
							mode_d = M_RUBY_LEAD;
						end else begin
							do_place = 1'b1;
							full     = 1'b1;
						end
					end
					M_RUBY_LEAD: begin
						mode_d   = M_RUBY_BASE;
						code     = {lead_q, c};
						do_place = 1'b1;
						full     = 1'b1;
					end
					M_RUBY_READ: begin
						if (c == CH_BRACE_CLOSE) mode_d = M_IDLE;
					end
					default: begin
						mode_d = M_IDLE;
						if (c == CH_BACKSLASH) mode_d = M_ESC;
						else if (c == CH_BRACE_OPEN) mode_d = M_RUBY_BASE;
						else if (is_lead(c)) begin
							lead_d = c;
							mode_d = M_LEAD;
						end else do_place = 1'b1;
					end
				endcase
				// an unfinished sequence is dropped at the end of a string
				if (item.end_of_string) mode_d = M_IDLE;
			end
			default: ;
		endcase
	end

	// placement: break first when the pen has reached the limit, unless kinsoku lets a full-width hanging mark stay
	always_comb begin
		brk  = ($signed({{2{col_q[15]}}, col_q}) >= $signed(cfg.limit)) &&
			!(may_hang && cfg.kinsoku && is_hanging(code));
		pcol = brk ? cfg.box_left : col_q;
		prow = brk ? row_q + {7'b0, cfg.line_step} : row_q;
		tsum = {1'b0, time_q} + {{(33 - STEP_W){1'b0}}, cfg.step};
	end

	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		time_d    = time_q;
		res_valid = 1'b0;
		res       = '0;
		if (item.cmd == CMD_PEN) begin
			col_d = item.new_pen_x;
			row_d = item.new_pen_y;
		end
		if (do_clear) begin
			col_d       = cfg.box_left;
			row_d       = cfg.box_top;
			time_d      = '0;
			res_valid   = 1'b1;
			res.kind    = 1'b1;
			res.glyph_x = cfg.box_left;
			res.glyph_y = cfg.box_top;
		end
		if (do_break) begin
			col_d = cfg.box_left;
			row_d = row_q + {7'b0, cfg.line_step};
		end
		if (do_place) begin
			res_valid      = 1'b1;
			res.glyph_code = code;
			res.glyph_x    = pcol;
			res.glyph_y    = prow;
			res.start_ms   = time_q;
			time_d         = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
			col_d          = pcol + {7'b0, full ? cfg.adv_full : cfg.adv_half};
			row_d          = prow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			lead_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
			time_q <= '0;
		end else if (en) begin
			mode_q <= mode_d;
			lead_q <= lead_d;
			col_q  <= col_d;
			row_q  <= row_d;
			time_q <= time_d;
		end
	end

endmodule

/* hdl/text_glyph_layout.sv */
// Text glyph layout.
// Input channel in_ch carries one item per handshake: a text byte (with an
// end-of-string mark), an external clear, or a pen position. Output channel
// out_ch carries at most one result per input item: a placed glyph (raw code,
// pen position, reveal start time) or a clear notice.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// while no item is in flight; the block does not enforce this. Derived values
// (line limit, advances, time step) are registered from the written values.
// An item is registered in the input register at acceptance; its result is
// then loaded into the output register, which drives out_ch, once that register
// is free or being read, so a stalled receiver can hold the item back.
// Throughput is one item per cycle while out_ch is not stalled, as the parser
// and pen state update once for each processed item.
// Reset (arst_n low) returns the parser to idle, the pen to (0,0), the time
// base to zero, and the registers to their defaults; both channels empty.
// While the receiver stalls, one result waits in the output register and one
// further item can be held in the input register; after that in_ch.ready
// drops until out_ch moves again.
module text_glyph_layout
	import tgl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	tgl_in_if.sink      in_ch,
	tgl_out_if.source   out_ch
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    en;
	logic    res_valid;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	tgl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the held item is processed once the output register can take its result
	assign en          = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (in_ch.ready) valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.cmd           <= cmd_t'(in_ch.cmd);
			item_s1.text_byte     <= in_ch.text_byte;
			item_s1.end_of_string <= in_ch.end_of_string;
			item_s1.new_pen_x     <= in_ch.new_pen_x;
			item_s1.new_pen_y     <= in_ch.new_pen_y;
		end
	end

	tgl_layout u_layout (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= res_valid;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (en && res_valid) out_q <= res;
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.kind       = out_q.kind;
	assign out_ch.glyph_code = out_q.glyph_code;
	assign out_ch.glyph_x    = out_q.glyph_x;
	assign out_ch.glyph_y    = out_q.glyph_y;
	assign out_ch.start_ms   = out_q.start_ms;

endmodule
